/* rtl/jse_pkg.sv */
package jse_pkg;

	// default depth of the job queue between front and back
	localparam int JSE_QDEPTH = 4;

	localparam logic [1:0] MODE_UTF8   = 2'd0;
	localparam logic [1:0] MODE_LATIN1 = 2'd1;
	localparam logic [1:0] MODE_UTF16  = 2'd2;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	// length of a backslash-u escape in bytes
	localparam logic [3:0] UESC_LEN = 4'd6;

	typedef enum logic [1:0] {
		MK_NONE,
		MK_ESC2,
		MK_UESC,
		MK_UTF
	} main_kind_t;

	// one classified input item: optional escape of a held lead, then main part
	typedef struct packed {
		logic        pre_esc;
		logic [15:0] pre_val;
		main_kind_t  kind;
		logic [20:0] main_val;
		logic [2:0]  utf_len;
		logic        last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'b0, v}) : (8'h37 + {4'b0, v});
	endfunction

	function automatic logic [7:0] uesc_byte(input logic [15:0] val, input logic [2:0] k);
		logic [7:0] b;
		case (k)
			3'd0: b = CH_BSLASH;
			3'd1: b = CH_U;
			3'd2: b = hex_digit(val[15:12]);
			3'd3: b = hex_digit(val[11:8]);
			3'd4: b = hex_digit(val[7:4]);
			3'd5: b = hex_digit(val[3:0]);
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] utf_byte(input logic [20:0] cp, input logic [2:0] len,
			input logic [1:0] k);
		logic [7:0] b;
		b = 8'h00;
		case (len)
			3'd1: b = cp[7:0];
			3'd2: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			3'd3: begin
				case (k)
					2'd0: b = {4'b1110, cp[15:12]};
					2'd1: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd4: begin
				case (k)
					2'd0: b = {5'b11110, cp[20:18]};
					2'd1: b = {2'b10, cp[17:12]};
					2'd2: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// sort a code point into short escape, \u escape or UTF-8 of 1..4 bytes
	function automatic job_t classify_cp(input logic [20:0] cp);
		job_t j;
		j = '0;
		j.main_val = cp;
		case (cp)
			21'h22: begin j.kind = MK_ESC2; j.main_val = 21'h22; end
			21'h5C: begin j.kind = MK_ESC2; j.main_val = 21'h5C; end
			21'h2F: begin j.kind = MK_ESC2; j.main_val = 21'h2F; end
			21'h08: begin j.kind = MK_ESC2; j.main_val = 21'h62; end
			21'h0C: begin j.kind = MK_ESC2; j.main_val = 21'h66; end
			21'h0A: begin j.kind = MK_ESC2; j.main_val = 21'h6E; end
			21'h0D: begin j.kind = MK_ESC2; j.main_val = 21'h72; end
			21'h09: begin j.kind = MK_ESC2; j.main_val = 21'h74; end
			default: begin
				if (cp < 21'h20) begin
					j.kind = MK_UESC;
				end else if (cp <= 21'h7F) begin
					j.kind = MK_UTF;
					j.utf_len = 3'd1;
				end else if (cp <= 21'h7FF) begin
					j.kind = MK_UTF;
					j.utf_len = 3'd2;
				end else if (cp <= 21'hFFFF) begin
					j.kind = MK_UTF;
					j.utf_len = 3'd3;
				end else begin
					j.kind = MK_UTF;
					j.utf_len = 3'd4;
				end
			end
		endcase
		return j;
	endfunction

	function automatic logic [3:0] main_len(input job_t j);
		logic [3:0] n;
		case (j.kind)
			MK_ESC2: n = 4'd2;
			MK_UESC: n = UESC_LEN;
			MK_UTF:  n = {1'b0, j.utf_len};
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

/* rtl/json_string_escape_encoder.sv */
// Channel  Signals                                 Direction  Handshake
// input    char_unit[15:0], last_unit              in         in_valid / in_ready
// output   out_byte[7:0], run_last, string_end     out        out_valid / out_ready
// config   cfg_wdata[1:0] (input_mode)             in         cfg_we, no wait
//
// One output byte per cycle from the back end while jobs wait and out_ready allows;
// an item expands to 1 to 12 bytes (none for a held lead surrogate), so plain ASCII
// flows at one transaction per cycle when unstalled. The byte sequencer is the limit.
// The front classifies in the accept cycle; the queue entry and output register follow.
// Reset (arst_n low) clears mode to UTF-16, drops any held lead, empties the queue.
// Input stalls only when the job queue is full; output stalls back up the queue.
module json_string_escape_encoder #(
	parameter int QDEPTH = jse_pkg::JSE_QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] char_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        string_end
);
	import jse_pkg::*;

	// front -> queue -> back
	logic    q_push, q_pop;
	job_t    q_in_job, q_head;
	q_stat_t q_stat;

	// front: mode register, surrogate pairing, classification of each unit
	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_unit (char_unit),
		.last_unit (last_unit),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_job  (q_in_job)
	);

	// short job queue so front and back stall independently
	jse_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in_job),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	// back: walks each job one byte per cycle, when not stalled, into the output register
	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_stat     (q_stat),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

`ifndef SYNTH
	a_q_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_end_on_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_end) |-> run_last)
		else $error("string_end without run_last");
`endif

endmodule

/* rtl/jse_front.sv */
module jse_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [15:0]      char_unit,
	input  logic             last_unit,
	input  jse_pkg::q_stat_t q_stat,
	output logic             push,
	output jse_pkg::job_t    push_job
);
	import jse_pkg::*;

	logic [1:0]  mode_q;
	logic [15:0] held_lead_q;
	logic        lead_pending_q;

	logic is_lead, is_trail, accept, hold_next;
	job_t job;

	assign is_lead  = (char_unit[15:10] == 6'b110110);
	assign is_trail = (char_unit[15:10] == 6'b110111);
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		job = '0;
		hold_next = 1'b0;
		if (mode_q == MODE_UTF8 || mode_q == MODE_LATIN1) begin
			if (mode_q == MODE_UTF8 && char_unit[7]) begin
				// raw high byte, copied as is
				job.kind = MK_UTF;
				job.main_val = {13'b0, char_unit[7:0]};
				job.utf_len = 3'd1;
			end else begin
				job = classify_cp({13'b0, char_unit[7:0]});
			end
			job.pre_esc = lead_pending_q;
		end else if (lead_pending_q && is_trail) begin
			job = classify_cp(21'h10000 + {1'b0, held_lead_q[9:0], char_unit[9:0]});
		end else begin
			if (is_trail) begin
				job.kind = MK_UESC;
				job.main_val = {5'b0, char_unit};
			end else if (is_lead) begin
				if (last_unit) begin
					job.kind = MK_UESC;
					job.main_val = {5'b0, char_unit};
				end else begin
					hold_next = 1'b1;
				end
			end else begin
				job = classify_cp({5'b0, char_unit});
			end
			job.pre_esc = lead_pending_q;
		end
		job.pre_val = held_lead_q;
		job.last = last_unit;
	end

	assign push     = accept && (job.pre_esc || job.kind != MK_NONE);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF16;
			held_lead_q <= 16'h0000;
			lead_pending_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				lead_pending_q <= hold_next;
				held_lead_q <= hold_next ? char_unit : 16'h0000;
			end
		end
	end

endmodule

/* rtl/jse_queue.sv */
module jse_queue #(
	parameter int DEPTH = jse_pkg::JSE_QDEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jse_pkg::job_t    push_job,
	input  logic             pop,
	output jse_pkg::job_t    head,
	output jse_pkg::q_stat_t stat
);
	import jse_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/jse_back.sv */
module jse_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jse_pkg::job_t    head,
	input  jse_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             string_end
);
	import jse_pkg::*;

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q, string_end_q;

	logic [3:0] pre_len, total, j;
	logic       in_pre, end_byte, load;
	logic [7:0] main_b, byte_d;

	always_comb begin
		pre_len = head.pre_esc ? UESC_LEN : 4'd0;
		total = pre_len + main_len(head);
		in_pre = head.pre_esc && (idx_q < UESC_LEN);
		j = idx_q - pre_len;
		case (head.kind)
			MK_ESC2: main_b = (j == 4'd0) ? CH_BSLASH : head.main_val[7:0];
			MK_UESC: main_b = uesc_byte(head.main_val[15:0], j[2:0]);
			MK_UTF:  main_b = utf_byte(head.main_val, head.utf_len, j[1:0]);
			default: main_b = 8'h00;
		endcase
		byte_d = in_pre ? uesc_byte(head.pre_val, idx_q[2:0]) : main_b;
		end_byte = (idx_q == total - 4'd1);
	end

	assign load = !q_stat.empty && (!out_valid_q || out_ready);
	assign pop  = load && end_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= 4'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= end_byte ? 4'd0 : idx_q + 4'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_d;
			run_last_q <= end_byte;
			string_end_q <= end_byte && head.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

endmodule

/* tb/escape_stream_checker.sv */
module escape_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] char_unit,
	input  logic        last_unit,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        run_last,
	input  logic        string_end,
	output int          mismatch_count,
	output int          bytes_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import jse_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       str_end;
	} esc_byte_t;

	esc_byte_t   expected_bytes[$];
	logic [1:0]  mode_q;
	logic [15:0] lead_q;
	logic        lead_held;
	logic [7:0]  run_buf[12];
	int          run_len;

	function automatic void put_byte(input logic [7:0] b);
		if (run_len < 12) begin
			run_buf[run_len] = b;
			run_len++;
		end
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return {4'h3, v};
		return 8'h41 + 8'(v - 4'd10);
	endfunction

	function automatic void put_uesc(input logic [15:0] v);
		put_byte("\\");
		put_byte("u");
		put_byte(hex_char(v[15:12]));
		put_byte(hex_char(v[11:8]));
		put_byte(hex_char(v[7:4]));
		put_byte(hex_char(v[3:0]));
	endfunction

	function automatic void put_cp(input logic [20:0] cp);
		case (cp)
			21'h22: begin put_byte("\\"); put_byte("\""); end
			21'h5C: begin put_byte("\\"); put_byte("\\"); end
			21'h2F: begin put_byte("\\"); put_byte("/"); end
			21'h08: begin put_byte("\\"); put_byte("b"); end
			21'h0C: begin put_byte("\\"); put_byte("f"); end
			21'h0A: begin put_byte("\\"); put_byte("n"); end
			21'h0D: begin put_byte("\\"); put_byte("r"); end
			21'h09: begin put_byte("\\"); put_byte("t"); end
			default: begin
				if (cp < 21'h20) begin
					put_uesc(cp[15:0]);
				end else if (cp <= 21'h7F) begin
					put_byte(cp[7:0]);
				end else if (cp <= 21'h7FF) begin
					put_byte({3'b110, cp[10:6]});
					put_byte({2'b10, cp[5:0]});
				end else if (cp <= 21'hFFFF) begin
					put_byte({4'b1110, cp[15:12]});
					put_byte({2'b10, cp[11:6]});
					put_byte({2'b10, cp[5:0]});
				end else begin
					put_byte({5'b11110, cp[20:18]});
					put_byte({2'b10, cp[17:12]});
					put_byte({2'b10, cp[11:6]});
					put_byte({2'b10, cp[5:0]});
				end
			end
		endcase
	endfunction

	// expected bytes for one accepted code unit, appended to the queue
	function automatic void predict_escape(input logic [15:0] cu, input logic last);
		logic is_lead;
		logic is_trail;
		is_lead  = (cu[15:10] == 6'b110110);
		is_trail = (cu[15:10] == 6'b110111);
		run_len  = 0;
		if (mode_q == MODE_UTF8 || mode_q == MODE_LATIN1) begin
			if (lead_held) begin
				put_uesc(lead_q);
				lead_held = 1'b0;
				lead_q    = '0;
			end
			if (mode_q == MODE_UTF8 && cu[7])
				put_byte(cu[7:0]);
			else
				put_cp({13'b0, cu[7:0]});
		end else if (lead_held && is_trail) begin
			lead_held = 1'b0;
			put_cp(21'h10000 + {1'b0, lead_q[9:0], cu[9:0]});
			lead_q = '0;
		end else begin
			if (lead_held) begin
				put_uesc(lead_q);
				lead_held = 1'b0;
				lead_q    = '0;
			end
			if (is_trail) begin
				put_uesc(cu);
			end else if (is_lead) begin
				if (last) begin
					put_uesc(cu);
				end else begin
					lead_q    = cu;
					lead_held = 1'b1;
				end
			end else begin
				put_cp({5'b0, cu});
			end
		end
		for (int i = 0; i < run_len; i++)
			expected_bytes.push_back({run_buf[i], i == run_len - 1, i == run_len - 1 && last});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		esc_byte_t want;
		if (!arst_n) begin
			mode_q    = MODE_UTF16;
			lead_q    = '0;
			lead_held = 1'b0;
			expected_bytes.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_we)
				mode_q = cfg_wdata;
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					if (mismatch_count < 10)
						$display("%t unexpected byte %02h run_last %0b string_end %0b",
							$realtime, out_byte, run_last, string_end);
					mismatch_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (want != {out_byte, run_last, string_end}) begin
						if (mismatch_count < 10)
							$display("%t byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
								$realtime, want.data, want.run_end, want.str_end,
								out_byte, run_last, string_end);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_escape(char_unit, last_unit);
		end
		bytes_owed = expected_bytes.size();
	end

endmodule

/* tb/json_string_escape_encoder_tb.sv */
module json_string_escape_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import jse_pkg::*;

	// mode 3 decodes as UTF-16 in the block
	localparam logic [1:0] MODE_UTF16_ALT = 2'd3;

	// characters that take a two-byte backslash escape
	localparam logic [7:0] ESCAPED_CHARS[8] = '{8'h22, 8'h5C, 8'h2F, 8'h08,
		8'h0C, 8'h0A, 8'h0D, 8'h09};

	// code points at the class boundaries: controls, short escapes, 1/2/3-byte UTF-8
	localparam logic [15:0] UTF16_EDGES[15] = '{16'h0000, 16'h001F, 16'h0022, 16'h005C,
		16'h002F, 16'h0008, 16'h000C, 16'h000A, 16'h000D, 16'h0009, 16'h007F,
		16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] char_unit;
	logic        last_unit;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        string_end;

	int mismatch_count;
	int bytes_owed;

	// idle rates in percent, changed per phase; zero means back-to-back
	int send_gap_pct;
	int stall_pct;

	json_string_escape_encoder dut (.*);

	escape_stream_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// sink side: random stall bursts, otherwise always ready
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// one input transaction; valid stays up with a stable payload until taken
	task automatic send_unit(input logic [15:0] cu, input logic last);
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_unit <= cu;
		last_unit <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	// let everything drain, then give a possibly held lead time to settle
	// before touching the mode register
	task automatic write_mode(input logic [1:0] mode);
		in_valid <= 1'b0;
		do @(negedge clk); while (bytes_owed != 0);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed text with random content; pairs count as two units
	task automatic send_random_utf16(inout int sent);
		logic [15:0] cu;
		logic        last;
		last = ($urandom_range(0, 7) == 0);
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4: cu = 16'($urandom_range(16'h20, 16'h7F));
			5:             cu = {8'h00, ESCAPED_CHARS[$urandom_range(0, 7)]};
			6:             cu = 16'($urandom_range(0, 16'h1F));
			7, 8:          cu = 16'($urandom_range(16'h80, 16'h7FF));
			9, 10: begin
				if ($urandom_range(0, 1) == 0)
					cu = 16'($urandom_range(16'h800, 16'hD7FF));
				else
					cu = 16'($urandom_range(16'hE000, 16'hFFFF));
			end
			11, 12: begin
				// well-formed surrogate pair
				send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
				sent++;
				cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
			end
			13:      cu = 16'($urandom_range(16'hD800, 16'hDBFF));
			14:      cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
			default: cu = 16'($urandom);
		endcase
		send_unit(cu, last);
		sent++;
	endtask

	// byte modes ignore the upper half, so it is always random
	task automatic send_random_byte(inout int sent);
		logic [7:0] lo;
		case ($urandom_range(0, 7))
			0, 1, 2, 3: lo = 8'($urandom_range(0, 255));
			4:          lo = ESCAPED_CHARS[$urandom_range(0, 7)];
			5:          lo = 8'($urandom_range(0, 8'h1F));
			6:          lo = 8'($urandom_range(8'h20, 8'h7F));
			default:    lo = 8'($urandom_range(8'h80, 8'hFF));
		endcase
		send_unit({8'($urandom), lo}, $urandom_range(0, 7) == 0);
		sent++;
	endtask

	initial begin
		logic [1:0] mode;
		int         sent;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		char_unit    = '0;
		last_unit    = 1'b0;
		send_gap_pct = 0;
		stall_pct    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, UTF-16 mode out of reset: class boundaries and every short escape
		send_gap_pct = 20;
		stall_pct    = 20;
		foreach (UTF16_EDGES[i])
			send_unit(UTF16_EDGES[i], i == 14);
		// pair at the surrogate extremes, lone trail, lead broken by ASCII,
		// lead flushed as an escape by the end of the string
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDFFF, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hD834, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hDBFF, 1'b1);

		// lead held across a switch to a byte mode: escaped before the byte
		send_unit(16'hD83D, 1'b0);
		write_mode(MODE_UTF8);
		send_unit(16'h00C3, 1'b0);
		send_unit(16'hFF80, 1'b1);
		write_mode(MODE_LATIN1);
		send_unit(16'h00FF, 1'b0);
		send_unit(16'h1280, 1'b1);
		write_mode(MODE_UTF16_ALT);
		send_unit(16'hD83D, 1'b0);
		send_unit(16'hDE00, 1'b1);

		// random phases over all mode values; the last one runs without idling
		for (int p = 0; p < 10; p++) begin
			case (p % 5)
				0:       mode = MODE_UTF8;
				1:       mode = MODE_LATIN1;
				2:       mode = MODE_UTF16;
				3:       mode = MODE_UTF16_ALT;
				default: mode = 2'($urandom_range(0, 3));
			endcase
			if (p == 9) begin
				mode         = MODE_UTF16;
				send_gap_pct = 0;
				stall_pct    = 0;
			end else begin
				send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
				stall_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
			end
			write_mode(mode);
			sent = 0;
			while (sent < 45) begin
				if (mode == MODE_UTF8 || mode == MODE_LATIN1)
					send_random_byte(sent);
				else
					send_random_utf16(sent);
			end
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (bytes_owed != 0);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && bytes_owed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
